/* hw/rtl/qacc_pkg.sv */
// Shared types, widths and codes for the quaternion accumulator.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none
package qacc_pkg;
	localparam int CW    = 24;            // component width
	localparam int FB    = 16;            // fraction bits
	localparam int PW    = 2 * CW;        // product width
	localparam int AW    = 2 * CW + 2;    // accumulator width
	localparam int LW    = CW + 1;        // length (square root) width
	localparam int SQW   = 2 * LW;        // radicand width
	localparam int DW    = CW + FB + 1;   // dividend / quotient width
	localparam int CNTW  = $clog2(DW + 1);
	localparam int SQCW  = $clog2(LW + 1);

	localparam logic [2:0] ACT_LOAD = 3'd0;
	localparam logic [2:0] ACT_MUL  = 3'd1;
	localparam logic [2:0] ACT_VEC  = 3'd2;
	localparam logic [2:0] ACT_CONJ = 3'd3;
	localparam logic [2:0] ACT_NORM = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SAT  = 2'd1;
	localparam logic [1:0] STAT_ZERO = 2'd2;

	localparam logic [1:0] IDX_X = 2'd0;
	localparam logic [1:0] IDX_Y = 2'd1;
	localparam logic [1:0] IDX_Z = 2'd2;
	localparam logic [1:0] IDX_W = 2'd3;

	typedef logic signed [CW-1:0] comp_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} quat_t;

	typedef struct packed {
		logic [1:0] hidx;
		logic [1:0] oidx;
		logic       neg;
	} term_t;

	typedef struct packed {
		logic            clear;
		logic            mul_en;
		logic            neg;
		comp_t           a;
		comp_t           b;
		logic            div_load;
		logic            div_step;
		logic [LW-1:0]   divisor;
		comp_t           comp;
	} lane_cmd_t;

	typedef struct packed {
		logic signed [AW-1:0] acc;
		comp_t                prod_res;
		logic                 prod_sat;
		comp_t                norm_res;
		logic                 norm_sat;
	} lane_res_t;

	function automatic comp_t pick(input quat_t q, input logic [1:0] idx);
		comp_t r;
		case (idx)
			IDX_X:   r = q.x;
			IDX_Y:   r = q.y;
			IDX_Z:   r = q.z;
			default: r = q.w;
		endcase
		return r;
	endfunction

	// Hamilton product terms: lane (result component) and step give
	// held component, operand component and sign.
	function automatic term_t term_sel(input logic [1:0] lane, input logic [1:0] step);
		term_t t;
		case ({lane, step})
			{IDX_X, 2'd0}: t = '{IDX_X, IDX_W, 1'b0};
			{IDX_X, 2'd1}: t = '{IDX_W, IDX_X, 1'b0};
			{IDX_X, 2'd2}: t = '{IDX_Y, IDX_Z, 1'b0};
			{IDX_X, 2'd3}: t = '{IDX_Z, IDX_Y, 1'b1};
			{IDX_Y, 2'd0}: t = '{IDX_Y, IDX_W, 1'b0};
			{IDX_Y, 2'd1}: t = '{IDX_W, IDX_Y, 1'b0};
			{IDX_Y, 2'd2}: t = '{IDX_Z, IDX_X, 1'b0};
			{IDX_Y, 2'd3}: t = '{IDX_X, IDX_Z, 1'b1};
			{IDX_Z, 2'd0}: t = '{IDX_Z, IDX_W, 1'b0};
			{IDX_Z, 2'd1}: t = '{IDX_W, IDX_Z, 1'b0};
			{IDX_Z, 2'd2}: t = '{IDX_X, IDX_Y, 1'b0};
			{IDX_Z, 2'd3}: t = '{IDX_Y, IDX_X, 1'b1};
			{IDX_W, 2'd0}: t = '{IDX_W, IDX_W, 1'b0};
			{IDX_W, 2'd1}: t = '{IDX_X, IDX_X, 1'b1};
			{IDX_W, 2'd2}: t = '{IDX_Y, IDX_Y, 1'b1};
			default:       t = '{IDX_Z, IDX_Z, 1'b1};
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/qacc_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on qacc_pkg for the component type.
`timescale 1ns / 1ps
`default_nettype none
interface qacc_req_if;
	logic                valid;
	logic                ready;
	logic [2:0]          action;
	qacc_pkg::comp_t     in_x;
	qacc_pkg::comp_t     in_y;
	qacc_pkg::comp_t     in_z;
	qacc_pkg::comp_t     in_w;
	modport source (output valid, action, in_x, in_y, in_z, in_w, input ready);
	modport sink (input valid, action, in_x, in_y, in_z, in_w, output ready);
endinterface

interface qacc_rsp_if;
	logic                valid;
	logic                ready;
	qacc_pkg::comp_t     out_x;
	qacc_pkg::comp_t     out_y;
	qacc_pkg::comp_t     out_z;
	qacc_pkg::comp_t     out_w;
	logic [1:0]          status;
	modport source (output valid, out_x, out_y, out_z, out_w, status, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qacc_lane.sv */
// One component lane: multiply-accumulate with round/saturate, and a
// restoring divider for normalize. Depends on qacc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qacc_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire qacc_pkg::lane_cmd_t cmd,
	output qacc_pkg::lane_res_t      res
);
	localparam int CW = qacc_pkg::CW;
	localparam int AW = qacc_pkg::AW;
	localparam int PW = qacc_pkg::PW;
	localparam int LW = qacc_pkg::LW;
	localparam int DW = qacc_pkg::DW;
	localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (qacc_pkg::FB - 1);
	localparam logic signed [AW-1:0] CMAX_A = (AW'(1) <<< (CW - 1)) - AW'(1);
	localparam logic signed [AW-1:0] CMIN_A = -CMAX_A - AW'(1);
	localparam logic [DW-1:0] QMAX_P = DW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [DW-1:0] QMAX_N = DW'(64'd1 << (CW - 1));

	logic signed [PW-1:0] prod_s1;
	logic                 neg_s1;
	logic                 en_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] rnd;

	logic [LW:0]          rem_q;
	logic [DW-1:0]        dvd_q;
	logic [LW-1:0]        dsr_q;
	logic                 sgn_q;
	logic [LW:0]          rem_sh;
	logic [CW-1:0]        mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= cmd.a * cmd.b;
		neg_s1  <= cmd.neg;
		if (cmd.clear) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= neg_s1 ? acc_q - prod_ext : acc_q + prod_ext;
		end
	end

	assign prod_ext = AW'(prod_s1);
	assign rnd      = (acc_q + HALF_A) >>> qacc_pkg::FB;

	always_comb begin
		res.acc = acc_q;
		if (rnd > CMAX_A) begin
			res.prod_res = CW'(CMAX_A);
			res.prod_sat = 1'b1;
		end else if (rnd < CMIN_A) begin
			res.prod_res = CW'(CMIN_A);
			res.prod_sat = 1'b1;
		end else begin
			res.prod_res = CW'(rnd);
			res.prod_sat = 1'b0;
		end
	end

	// restoring division, one quotient bit per step
	assign mag    = cmd.comp[CW-1] ? CW'(-cmd.comp) : CW'(cmd.comp);
	assign rem_sh = {rem_q[LW-1:0], dvd_q[DW-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= '0;
			dvd_q <= (DW'(mag) << qacc_pkg::FB) + DW'(cmd.divisor >> 1);
			dsr_q <= cmd.divisor;
			sgn_q <= cmd.comp[CW-1];
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, dsr_q}) begin
				rem_q <= rem_sh - {1'b0, dsr_q};
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (sgn_q) begin
			res.norm_sat = dvd_q > QMAX_N;
			res.norm_res = res.norm_sat ? CW'(CMIN_A) : CW'(-dvd_q);
		end else begin
			res.norm_sat = dvd_q > QMAX_P;
			res.norm_res = res.norm_sat ? CW'(CMAX_A) : CW'(dvd_q);
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/qacc_isqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on qacc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module qacc_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [qacc_pkg::SQW-1:0]      radicand,
	output logic                               done,
	output logic [qacc_pkg::LW-1:0]            root
);
	localparam int LW  = qacc_pkg::LW;
	localparam int SQW = qacc_pkg::SQW;

	logic                       run_q;
	logic                       done_q;
	logic [qacc_pkg::SQCW-1:0]  cnt_q;
	logic [SQW-1:0]             rad_q;
	logic [LW:0]                rem_q;
	logic [LW-1:0]              root_q;
	logic [LW+2:0]              rem2;
	logic [LW+2:0]              trial;

	assign rem2  = {rem_q, rad_q[SQW-1 -: 2]};
	assign trial = {2'b00, root_q[LW-2:0], 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == qacc_pkg::SQCW'(LW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			if (rem2 >= trial) begin
				rem_q  <= (LW+1)'(rem2 - trial);
				root_q <= {root_q[LW-2:0], 1'b1};
			end else begin
				rem_q  <= (LW+1)'(rem2);
				root_q <= {root_q[LW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

/* hw/rtl/quaternion_accumulator_top.sv */
// Quaternion accumulator top: control sequencer, four component lanes,
// merge of lane squares and the shared square root. Depends on qacc_pkg,
// qacc_if, qacc_lane and qacc_isqrt.
//
// Usage: req carries one word (action, in_x..in_w); rsp returns one word
// (out_x..out_w, status) per request, in order. A word is moved when valid
// and ready are both high. One request is worked on at a time.
// Steps from accept to rsp valid:
//   load, conjugate, unused codes: result word is formed at accept
//   multiply (quaternion or vector): each lane runs four products
//     through its one multiplier, then accumulates
//   normalize: the one-bit-per-cycle square root, followed by the
//     lanes' dividers
//   normalize of zero length: square root and dividers are skipped
// The rsp register holds a finished word while the receiver stalls; req is
// ready again once the result has moved into the rsp register, so the next
// request may run meanwhile and waits only if the rsp register is still full
// when it ends.
// Reset clears the held quaternion to (0, 0, 0, 1.0) and empties rsp.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_accumulator_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qacc_req_if.sink   req,
	qacc_rsp_if.source rsp
);
	localparam int CW   = qacc_pkg::CW;
	localparam int DW   = qacc_pkg::DW;
	localparam int CNTW = qacc_pkg::CNTW;
	localparam qacc_pkg::comp_t CMAX = qacc_pkg::comp_t'((64'd1 << (CW - 1)) - 64'd1);
	localparam qacc_pkg::comp_t CMIN = qacc_pkg::comp_t'(64'd1 << (CW - 1));
	localparam qacc_pkg::comp_t ONE  = qacc_pkg::comp_t'(64'd1 << qacc_pkg::FB);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]               state_q;
	logic [CNTW-1:0]          cnt_q;
	qacc_pkg::quat_t          held_q;
	qacc_pkg::quat_t          op_q;
	qacc_pkg::quat_t          res_q;
	logic [1:0]               stat_q;
	qacc_pkg::quat_t          out_q;
	logic [1:0]               out_stat_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     sq_done;
	logic [qacc_pkg::LW-1:0]  root;
	logic [qacc_pkg::SQW-1:0] sum_sq;
	logic                     sqrt_start;
	qacc_pkg::lane_cmd_t      cmd [4];
	qacc_pkg::lane_res_t      lres [4];
	qacc_pkg::quat_t          mul_res;
	qacc_pkg::quat_t          norm_res;
	logic                     mul_sat;
	logic                     norm_sat;
	qacc_pkg::quat_t          conj;
	logic                     conj_sat;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_lane
			qacc_pkg::term_t t;
			qacc_pkg::comp_t own;
			assign t   = qacc_pkg::term_sel(2'(g), cnt_q[1:0]);
			assign own = qacc_pkg::pick(held_q, 2'(g));
			always_comb begin
				cmd[g].clear    = accept;
				cmd[g].mul_en   = 1'b0;
				cmd[g].neg      = 1'b0;
				cmd[g].a        = own;
				cmd[g].b        = own;
				cmd[g].div_load = (state_q == S_SQRT) && sq_done;
				cmd[g].div_step = (state_q == S_DIV);
				cmd[g].divisor  = root;
				cmd[g].comp     = own;
				if (state_q == S_MUL && cnt_q < CNTW'(4)) begin
					cmd[g].mul_en = 1'b1;
					cmd[g].neg    = t.neg;
					cmd[g].a      = qacc_pkg::pick(held_q, t.hidx);
					cmd[g].b      = qacc_pkg::pick(op_q, t.oidx);
				end else if (state_q == S_SQ && cnt_q == '0) begin
					cmd[g].mul_en = 1'b1;
				end
			end
			qacc_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd[g]),
				.res    (lres[g])
			);
		end
	endgenerate

	// merge: squares are nonnegative and below 2^(2*CW)
	assign sum_sq = qacc_pkg::SQW'(lres[0].acc) + qacc_pkg::SQW'(lres[1].acc)
		+ qacc_pkg::SQW'(lres[2].acc) + qacc_pkg::SQW'(lres[3].acc);
	assign sqrt_start = (state_q == S_SQ) && (cnt_q == CNTW'(2)) && (sum_sq != '0);

	qacc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_sq),
		.done     (sq_done),
		.root     (root)
	);

	assign mul_res  = '{lres[0].prod_res, lres[1].prod_res, lres[2].prod_res,
		lres[3].prod_res};
	assign mul_sat  = lres[0].prod_sat | lres[1].prod_sat | lres[2].prod_sat
		| lres[3].prod_sat;
	assign norm_res = '{lres[0].norm_res, lres[1].norm_res, lres[2].norm_res,
		lres[3].norm_res};
	assign norm_sat = lres[0].norm_sat | lres[1].norm_sat | lres[2].norm_sat
		| lres[3].norm_sat;

	always_comb begin
		conj.x   = (held_q.x == CMIN) ? CMAX : -held_q.x;
		conj.y   = (held_q.y == CMIN) ? CMAX : -held_q.y;
		conj.z   = (held_q.z == CMIN) ? CMAX : -held_q.z;
		conj.w   = held_q.w;
		conj_sat = (held_q.x == CMIN) || (held_q.y == CMIN) || (held_q.z == CMIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			held_q      <= '{'0, '0, '0, ONE};
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (req.action)
							qacc_pkg::ACT_LOAD: begin
								held_q  <= '{req.in_x, req.in_y, req.in_z, req.in_w};
								state_q <= S_DONE;
							end
							qacc_pkg::ACT_MUL,
							qacc_pkg::ACT_VEC: state_q <= S_MUL;
							qacc_pkg::ACT_NORM: state_q <= S_SQ;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(5)) begin
						held_q  <= mul_res;
						state_q <= S_DONE;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(2)) begin
						state_q <= (sum_sq == '0) ? S_DONE : S_SQRT;
					end
				end
				S_SQRT: begin
					cnt_q <= '0;
					if (sq_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(DW)) begin
						held_q  <= norm_res;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word and operand capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= '{req.in_x, req.in_y, req.in_z,
				(req.action == qacc_pkg::ACT_VEC) ? '0 : req.in_w};
			res_q  <= held_q;
			stat_q <= qacc_pkg::STAT_OK;
			case (req.action)
				qacc_pkg::ACT_LOAD: res_q <= '{req.in_x, req.in_y, req.in_z, req.in_w};
				qacc_pkg::ACT_CONJ: begin
					res_q  <= conj;
					stat_q <= conj_sat ? qacc_pkg::STAT_SAT : qacc_pkg::STAT_OK;
				end
				default: ;
			endcase
		end else if (state_q == S_MUL && cnt_q == CNTW'(5)) begin
			res_q  <= mul_res;
			stat_q <= mul_sat ? qacc_pkg::STAT_SAT : qacc_pkg::STAT_OK;
		end else if (state_q == S_SQ && cnt_q == CNTW'(2) && sum_sq == '0) begin
			res_q  <= held_q;
			stat_q <= qacc_pkg::STAT_ZERO;
		end else if (state_q == S_DIV && cnt_q == CNTW'(DW)) begin
			res_q  <= norm_res;
			stat_q <= norm_sat ? qacc_pkg::STAT_SAT : qacc_pkg::STAT_OK;
		end
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_q      <= res_q;
			out_stat_q <= stat_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.out_x  = out_q.x;
	assign rsp.out_y  = out_q.y;
	assign rsp.out_z  = out_q.z;
	assign rsp.out_w  = out_q.w;
	assign rsp.status = out_stat_q;
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for quaternion_accumulator_top: directed and random words
// with random idling on both channels, checked against a bit-exact predictor.
// Depends on qacc_pkg, qacc_if and the quaternion_accumulator_top RTL.
`timescale 1ns / 1ps
module tb_top;
	import qacc_pkg::*;

	localparam longint C_MAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint C_MIN = -C_MAX - 1;
	localparam logic [2:0] ACT_SPARE = 3'd5;

	typedef struct {
		comp_t      x, y, z, w;
		logic [1:0] status;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	qacc_req_if req ();
	qacc_rsp_if rsp ();

	quaternion_accumulator_top dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	longint  held_x, held_y, held_z, held_w;
	result_t pending_results[$];
	int      mismatches = 0;
	bit      timed_out = 1'b0;
	bit      calm = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("quaternion_accumulator_top regression: fail");
		$finish;
	end

	function automatic longint clamp(input longint v, inout bit hit);
		if (v > C_MAX) begin
			hit = 1'b1;
			return C_MAX;
		end
		if (v < C_MIN) begin
			hit = 1'b1;
			return C_MIN;
		end
		return v;
	endfunction

	// exact sum of products, rounded half up to the component scale
	function automatic longint round_up(input longint s);
		return (s + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned magnitude(input longint c);
		return c < 0 ? longint'(-c) : c;
	endfunction

	function automatic longint scale_to_unit(input longint c, input longint unsigned len,
			inout bit hit);
		longint unsigned q;
		q = ((magnitude(c) << FB) + (len >> 1)) / len;
		return clamp(c < 0 ? -longint'(q) : longint'(q), hit);
	endfunction

	task automatic hamilton_step(input longint qx, qy, qz, qw, inout bit hit);
		longint nx, ny, nz, nw;
		nw = round_up(held_w*qw - held_x*qx - held_y*qy - held_z*qz);
		nx = round_up(held_x*qw + held_w*qx + held_y*qz - held_z*qy);
		ny = round_up(held_y*qw + held_w*qy + held_z*qx - held_x*qz);
		nz = round_up(held_z*qw + held_w*qz + held_x*qy - held_y*qx);
		held_x = clamp(nx, hit);
		held_y = clamp(ny, hit);
		held_z = clamp(nz, hit);
		held_w = clamp(nw, hit);
	endtask

	task automatic predict_word(input logic [2:0] act, input comp_t ix, iy, iz, iw);
		result_t r;
		bit hit = 1'b0;
		longint unsigned sum, len;
		r.status = STAT_OK;
		case (act)
			ACT_LOAD: begin
				held_x = ix; held_y = iy; held_z = iz; held_w = iw;
			end
			ACT_MUL: hamilton_step(ix, iy, iz, iw, hit);
			ACT_VEC: hamilton_step(ix, iy, iz, 0, hit);
			ACT_NORM: begin
				sum = magnitude(held_x) ** 2 + magnitude(held_y) ** 2
					+ magnitude(held_z) ** 2 + magnitude(held_w) ** 2;
				if (sum == 0) begin
					r.status = STAT_ZERO;
				end else begin
					len = int_sqrt(sum);
					held_x = scale_to_unit(held_x, len, hit);
					held_y = scale_to_unit(held_y, len, hit);
					held_z = scale_to_unit(held_z, len, hit);
					held_w = scale_to_unit(held_w, len, hit);
				end
			end
			default: ;
		endcase
		r.x = held_x; r.y = held_y; r.z = held_z; r.w = held_w;
		if (act == ACT_CONJ) begin
			r.x = clamp(-held_x, hit);
			r.y = clamp(-held_y, hit);
			r.z = clamp(-held_z, hit);
		end
		if (r.status == STAT_OK && hit) r.status = STAT_SAT;
		pending_results.push_back(r);
	endtask

	// one request word; returns at the accepting edge
	task automatic send_word(input logic [2:0] act, input comp_t ix, iy, iz, iw);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		req.action = act;
		req.in_x = ix; req.in_y = iy; req.in_z = iz; req.in_w = iw;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		predict_word(act, ix, iy, iz, iw);
	endtask

	// operands mostly near unit scale so products chain without saturating
	function automatic comp_t rand_comp();
		case ($urandom_range(0, 3))
			0: return comp_t'($urandom);
			1: return comp_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
			default: return comp_t'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
		endcase
	endfunction

	task automatic test_load_and_conjugate();
		send_word(ACT_CONJ, 0, 0, 0, 0);
		send_word(ACT_LOAD, comp_t'(C_MIN), comp_t'(C_MAX), comp_t'(C_MIN), comp_t'(C_MAX));
		send_word(ACT_CONJ, 0, 0, 0, 0);
		send_word(ACT_LOAD, comp_t'(C_MAX), comp_t'(-1), 24'sh5A5A5A, comp_t'(C_MIN));
		send_word(ACT_CONJ, 0, 0, 0, 0);
	endtask

	task automatic test_multiply();
		send_word(ACT_LOAD, 24'sh008000, 24'sh00C000, -24'sh004000, 24'sh010000);
		send_word(ACT_MUL, 24'sh000001, -24'sh000001, 24'sh00FFFF, 24'sh008000);
		send_word(ACT_VEC, 24'sh010000, 24'sh010000, -24'sh010000, comp_t'(C_MAX));
		send_word(ACT_MUL, comp_t'(C_MAX), comp_t'(C_MIN), comp_t'(C_MAX), comp_t'(C_MIN));
		send_word(ACT_VEC, comp_t'(C_MIN), comp_t'(C_MIN), comp_t'(C_MIN), 0);
		send_word(ACT_MUL, 0, 0, 0, 0);
	endtask

	task automatic test_normalize();
		send_word(ACT_NORM, 0, 0, 0, 0);
		send_word(ACT_LOAD, 24'sh030000, -24'sh040000, 0, 0);
		send_word(ACT_NORM, 0, 0, 0, 0);
		send_word(ACT_LOAD, 0, 0, 0, 24'sh000001);
		send_word(ACT_NORM, 0, 0, 0, 0);
		send_word(ACT_LOAD, comp_t'(C_MIN), comp_t'(C_MIN), comp_t'(C_MIN), comp_t'(C_MIN));
		send_word(ACT_NORM, 0, 0, 0, 0);
		send_word(ACT_LOAD, 24'sh000003, 0, 0, 0);
		send_word(ACT_NORM, 0, 0, 0, 0);
	endtask

	task automatic test_spare_codes();
		for (int a = ACT_SPARE; a <= 7; a++)
			send_word(3'(a), comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
				comp_t'($urandom));
		send_word(ACT_LOAD, 0, 0, 0, 0);
		send_word(ACT_NORM, 0, 0, 0, 0);
	endtask

	task automatic test_random(input int count);
		logic [2:0] act;
		for (int i = 0; i < count; i++) begin
			if (i % 200 == 100) calm = 1'b1;
			if (i % 200 == 150) calm = 1'b0;
			case ($urandom_range(0, 19))
				0, 1, 2:          act = ACT_LOAD;
				3, 4, 5, 6, 7, 8: act = ACT_MUL;
				9, 10, 11, 12:    act = ACT_VEC;
				13, 14:           act = ACT_CONJ;
				15, 16, 17:       act = ACT_NORM;
				18:               act = 3'($urandom_range(ACT_SPARE, 7));
				default:          act = 3'($urandom);
			endcase
			send_word(act, rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		calm = 1'b0;
	endtask

	// response side: random stall per word, stall-free while calm
	initial begin
		int stall = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0 && !calm) begin
				rsp.ready = 1'b0;
				stall--;
			end else begin
				rsp.ready = 1'b1;
			end
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				stall = $urandom_range(0, 4);
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: %h %h %h %h status %0d",
							rsp.out_x, rsp.out_y, rsp.out_z, rsp.out_w, rsp.status);
				end else begin
					result_t e;
					e = pending_results.pop_front();
					if (rsp.out_x !== e.x || rsp.out_y !== e.y || rsp.out_z !== e.z ||
							rsp.out_w !== e.w || rsp.status !== e.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h %h %h %h st %0d, got %h %h %h %h st %0d",
								e.x, e.y, e.z, e.w, e.status, rsp.out_x, rsp.out_y,
								rsp.out_z, rsp.out_w, rsp.status);
					end
				end
			end
		end
	end

	initial begin
		int waited = 0;
		req.valid = 1'b0;
		req.action = ACT_LOAD;
		req.in_x = 0; req.in_y = 0; req.in_z = 0; req.in_w = 0;
		held_x = 0; held_y = 0; held_z = 0; held_w = 64'sd1 <<< FB;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_load_and_conjugate();
		test_multiply();
		test_normalize();
		test_spare_codes();
		test_random(1200);
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) timed_out = 1'b1;
		repeat (100) @(posedge clk);
		if (mismatches == 0 && !timed_out && pending_results.size() == 0)
			$display("quaternion_accumulator_top regression: pass");
		else
			$display("quaternion_accumulator_top regression: fail");
		$finish;
	end
endmodule

/* quaternion_accumulator_top.f */
hw/rtl/qacc_pkg.sv
hw/rtl/qacc_if.sv
hw/rtl/qacc_lane.sv
hw/rtl/qacc_isqrt.sv
hw/rtl/quaternion_accumulator_top.sv
tb/tb_top.sv
